// ===== sv/rtm_pkg.sv =====
// ---------------------------------------------------------------------------
// rtm_pkg
// Types and codes shared by the range-table DFA matcher and its testbench.
// ---------------------------------------------------------------------------
package rtm_pkg;

	// Input transaction kinds, carried on s_tuser.
	localparam logic [1:0] ACT_WR_STATE = 2'd0;
	localparam logic [1:0] ACT_WR_CASE  = 2'd1;
	localparam logic [1:0] ACT_RUNE     = 2'd2;
	localparam logic [1:0] ACT_EMPTY    = 2'd3;

	// Kind of the character that follows the current rune.
	localparam logic [1:0] NK_OTHER   = 2'd0;
	localparam logic [1:0] NK_NEWLINE = 2'd1;
	localparam logic [1:0] NK_END     = 2'd2;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_START_PLAIN      = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_LINE_BEGIN = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_START_LINE_END   = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_START_BOTH       = 8'd3;

	// Freeze modes.
	localparam logic [1:0] FRZ_RUNNING = 2'd0;
	localparam logic [1:0] FRZ_NOGROW  = 2'd1;
	localparam logic [1:0] FRZ_FINAL   = 2'd2;

	// Key bit that marks an end of line or an end of text after the rune.
	localparam logic [16:0] KEY_EOL = 17'h10000;

	typedef struct packed {
		logic [12:0] case_count;
		logic [11:0] case_base;
		logic        is_loop;
		logic        is_final;
	} state_entry_t;

	typedef struct packed {
		logic [7:0]  target;
		logic [16:0] key;
	} case_entry_t;

	localparam int STATE_ENTRY_W = $bits(state_entry_t);
	localparam int CASE_ENTRY_W  = $bits(case_entry_t);

endpackage

// ===== sv/rtm_ram.sv =====
// ---------------------------------------------------------------------------
// rtm_ram
// Single-port-write, single-port-read table memory with registered read data.
// ---------------------------------------------------------------------------
module rtm_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 27
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== sv/range_table_dfa_matcher.sv =====
// ---------------------------------------------------------------------------
// range_table_dfa_matcher
// Table-driven DFA that reports the longest match length of a rune stream.
// ---------------------------------------------------------------------------
// Usage: the host first loads the state table and the case table with
// write transactions on the s_ channel (s_tuser selects the kind), and sets
// the four start-state registers on the cfg_ channel (always ready). Text
// then arrives as one rune transaction per character; the first rune of a
// text picks the start state. One result transaction appears on m_ after
// the rune whose next_kind marks the end of text, or after an empty-text
// transaction; table writes and other runes give none.
// Flow: a rune reads its state entry from the state table, then the compare
// unit walks its cases, one case per cycle out of the case memory; a frozen
// text skips both, and a loop state skips the walk. The final rune of a
// running text reads the state table once more before the output register
// is loaded. s_tready is high only while the sequencer is idle.
// The output register holds a result until m_tready takes it; the next
// input is still accepted, and only a further result waits for it.
// Reset clears the sequencer, the control registers and the output valid
// flag; the tables are not cleared and must be written before they are used.
// ---------------------------------------------------------------------------
module range_table_dfa_matcher #(
	parameter int          NUM_STATES     = 256,
	parameter int          NUM_CASES      = 4096,
	parameter int unsigned MAX_TEXT_BYTES = 65535
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [11:0] index, [12] entry_final, [13] entry_loop, [25:14] entry_case_base,
	// [38:26] entry_case_count, [55:39] case_key, [63:56] case_target,
	// [79:64] rune, [81:80] rune_bytes, [83:82] next_kind, [84] line_begin
	input  logic [87:0] s_tdata,
	// [1:0] action
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [16:0] match_length (signed)
	output logic [23:0] m_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	import rtm_pkg::*;

	localparam int SAW   = $clog2(NUM_STATES);
	localparam int CAW   = $clog2(NUM_CASES);
	localparam int SIW   = (SAW > 12) ? SAW : 12;
	localparam int CIW   = (CAW > 12) ? CAW : 12;
	localparam int OFF_W = $clog2(64'(MAX_TEXT_BYTES) + 64'd1);
	localparam int EXW   = (OFF_W > 17) ? OFF_W : 17;
	localparam logic [OFF_W:0]   MAX_OFF  = (OFF_W + 1)'(MAX_TEXT_BYTES);
	localparam logic [CAW-1:0]   LAST_CA  = CAW'(NUM_CASES - 1);
	localparam logic [16:0]      NS_CONST = 17'(NUM_STATES);
	localparam logic [20:0]      NC_CONST = 21'(NUM_CASES);

	// Sequencer states.
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_SREQ  = 4'd1;
	localparam logic [3:0] S_SEVAL = 4'd2;
	localparam logic [3:0] S_CREQ  = 4'd3;
	localparam logic [3:0] S_CEVAL = 4'd4;
	localparam logic [3:0] S_ADV   = 4'd5;
	localparam logic [3:0] S_FREQ  = 4'd6;
	localparam logic [3:0] S_FEVAL = 4'd7;
	localparam logic [3:0] S_EMIT  = 4'd8;

	// Input fields.
	logic [11:0] in_index;
	logic        in_entry_final;
	logic        in_entry_loop;
	logic [11:0] in_entry_case_base;
	logic [12:0] in_entry_case_count;
	logic [16:0] in_case_key;
	logic [7:0]  in_case_target;
	logic [15:0] in_rune;
	logic [1:0]  in_rune_bytes;
	logic [1:0]  in_next_kind;
	logic        in_line_begin;
	logic [1:0]  in_action;

	assign in_index            = s_tdata[11:0];
	assign in_entry_final      = s_tdata[12];
	assign in_entry_loop       = s_tdata[13];
	assign in_entry_case_base  = s_tdata[25:14];
	assign in_entry_case_count = s_tdata[38:26];
	assign in_case_key         = s_tdata[55:39];
	assign in_case_target      = s_tdata[63:56];
	assign in_rune             = s_tdata[79:64];
	assign in_rune_bytes       = s_tdata[81:80];
	assign in_next_kind        = s_tdata[83:82];
	assign in_line_begin       = s_tdata[84];
	assign in_action           = s_tuser;

	// Control state.
	logic [3:0]       state_q;
	logic [7:0]       start_q [4];
	logic [SAW-1:0]   cur_q;
	logic [OFF_W-1:0] off_q;
	logic [OFF_W-1:0] best_off_q;
	logic             best_none_q;
	logic [1:0]       freeze_q;
	logic             in_text_q;
	logic             out_valid_q;

	// Per-item working registers.
	logic             empty_q;
	logic             last_q;
	logic [16:0]      key_q;
	logic [1:0]       bytes_q;
	logic [CAW-1:0]   addr_q;
	logic [12:0]      j_q;
	logic [12:0]      count_q;
	logic [7:0]       prev_q;
	logic [16:0]      out_data_q;

	logic s_accept;
	assign s_accept  = s_tvalid && s_tready;
	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;

	// Reduction of a state number to the table depth: restoring remainder.
	function automatic logic [SAW-1:0] state_mod(input logic [7:0] v);
		logic [16:0] r;
		r = '0;
		for (int i = 7; i >= 0; i--) begin
			r = {r[15:0], v[i]};
			if (r >= NS_CONST) begin
				r = r - NS_CONST;
			end
		end
		return SAW'(r);
	endfunction

	function automatic logic [CAW-1:0] case_mod(input logic [11:0] v);
		logic [20:0] r;
		r = '0;
		for (int i = 11; i >= 0; i--) begin
			r = {r[19:0], v[i]};
			if (r >= NC_CONST) begin
				r = r - NC_CONST;
			end
		end
		return CAW'(r);
	endfunction

	// Table memories.
	logic [SIW-1:0] s_idx_ext;
	logic [CIW-1:0] c_idx_ext;
	logic           st_we;
	logic           cs_we;
	state_entry_t   st_wdata;
	case_entry_t    cs_wdata;
	state_entry_t   st_rdata;
	case_entry_t    cs_rdata;
	logic           st_re;
	logic           cs_re;
	logic [CAW-1:0] addr_nx;
	logic [CAW-1:0] cs_raddr;

	assign s_idx_ext = SIW'(in_index);
	assign c_idx_ext = CIW'(in_index);
	assign st_we = s_accept && (in_action == ACT_WR_STATE) && (32'(in_index) < NUM_STATES);
	assign cs_we = s_accept && (in_action == ACT_WR_CASE) && (32'(in_index) < NUM_CASES);

	assign st_wdata.is_final   = in_entry_final;
	assign st_wdata.is_loop    = in_entry_loop;
	assign st_wdata.case_base  = in_entry_case_base;
	assign st_wdata.case_count = in_entry_case_count;
	assign cs_wdata.key        = in_case_key;
	assign cs_wdata.target     = in_case_target;

	assign st_re    = (state_q == S_SREQ) || (state_q == S_FREQ);
	assign addr_nx  = (addr_q == LAST_CA) ? '0 : addr_q + 1'b1;
	// While walking, the next case is fetched ahead of the compare.
	assign cs_re    = (state_q == S_CREQ) || (state_q == S_CEVAL);
	assign cs_raddr = (state_q == S_CEVAL) ? addr_nx : addr_q;

	rtm_ram #(
		.DEPTH(NUM_STATES),
		.WIDTH(STATE_ENTRY_W)
	) u_state_ram (
		.clk  (clk),
		.we   (st_we),
		.waddr(s_idx_ext[SAW-1:0]),
		.wdata(st_wdata),
		.re   (st_re),
		.raddr(cur_q),
		.rdata(st_rdata)
	);

	rtm_ram #(
		.DEPTH(NUM_CASES),
		.WIDTH(CASE_ENTRY_W)
	) u_case_ram (
		.clk  (clk),
		.we   (cs_we),
		.waddr(c_idx_ext[CAW-1:0]),
		.wdata(cs_wdata),
		.re   (cs_re),
		.raddr(cs_raddr),
		.rdata(cs_rdata)
	);

	// Start-state selection and other helpers.
	logic [1:0]       start_sel;
	logic [SAW-1:0]   start_state;
	logic             frozen_now;
	logic [OFF_W:0]   off_sum;
	logic [OFF_W-1:0] off_nx;
	logic             key_above;
	logic             walk_last;
	logic             out_free;
	logic [EXW-1:0]   best_ext;

	assign start_sel   = (in_action == ACT_EMPTY) ? {1'b0, in_line_begin} :
	                     {(in_next_kind == NK_NEWLINE), in_line_begin};
	assign start_state = state_mod(start_q[start_sel]);
	assign frozen_now  = in_text_q && (freeze_q != FRZ_RUNNING);
	assign off_sum     = {1'b0, off_q} + (OFF_W + 1)'(bytes_q);
	assign off_nx      = (off_sum > MAX_OFF) ? MAX_OFF[OFF_W-1:0] : off_sum[OFF_W-1:0];
	assign key_above   = (cs_rdata.key > key_q);
	assign walk_last   = (j_q == (count_q - 13'd1));
	assign out_free    = !out_valid_q || m_tready;
	assign best_ext    = EXW'(best_off_q);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				start_q[i] <= '0;
			end
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_START_PLAIN:      start_q[0] <= cfg_data;
				REG_START_LINE_BEGIN: start_q[1] <= cfg_data;
				REG_START_LINE_END:   start_q[2] <= cfg_data;
				REG_START_BOTH:       start_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer and match state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cur_q       <= '0;
			off_q       <= '0;
			best_off_q  <= '0;
			best_none_q <= 1'b1;
			freeze_q    <= FRZ_RUNNING;
			in_text_q   <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (s_accept) begin
						case (in_action)
							ACT_RUNE: begin
								if (!in_text_q) begin
									cur_q       <= start_state;
									off_q       <= '0;
									best_none_q <= 1'b1;
									freeze_q    <= FRZ_RUNNING;
									in_text_q   <= 1'b1;
								end
								state_q <= frozen_now ? S_ADV : S_SREQ;
							end
							ACT_EMPTY: begin
								cur_q     <= start_state;
								off_q     <= '0;
								freeze_q  <= FRZ_RUNNING;
								in_text_q <= 1'b0;
								state_q   <= S_SREQ;
							end
							default: ;
						endcase
					end
				end
				S_SREQ: begin
					state_q <= S_SEVAL;
				end
				S_SEVAL: begin
					if (empty_q) begin
						best_off_q  <= '0;
						best_none_q <= !st_rdata.is_final;
						state_q     <= S_EMIT;
					end else begin
						if (st_rdata.is_final) begin
							best_off_q  <= off_q;
							best_none_q <= 1'b0;
						end
						if (st_rdata.is_loop) begin
							freeze_q <= st_rdata.is_final ? FRZ_FINAL : FRZ_NOGROW;
							state_q  <= S_ADV;
						end else if (st_rdata.case_count == '0) begin
							state_q <= S_ADV;
						end else begin
							state_q <= S_CREQ;
						end
					end
				end
				S_CREQ: begin
					state_q <= S_CEVAL;
				end
				S_CEVAL: begin
					// The last case whose start is at or below the key wins; a key
					// below every case takes the first one.
					if (key_above) begin
						cur_q   <= state_mod((j_q == '0) ? cs_rdata.target : prev_q);
						state_q <= S_ADV;
					end else if (walk_last) begin
						cur_q   <= state_mod(cs_rdata.target);
						state_q <= S_ADV;
					end
				end
				S_ADV: begin
					off_q <= off_nx;
					if (!last_q) begin
						state_q <= S_IDLE;
					end else if (freeze_q == FRZ_FINAL) begin
						best_off_q  <= off_nx;
						best_none_q <= 1'b0;
						state_q     <= S_EMIT;
					end else if (freeze_q == FRZ_RUNNING) begin
						state_q <= S_FREQ;
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_FREQ: begin
					state_q <= S_FEVAL;
				end
				S_FEVAL: begin
					if (st_rdata.is_final) begin
						best_off_q  <= off_q;
						best_none_q <= 1'b0;
					end
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						in_text_q <= 1'b0;
						freeze_q  <= FRZ_RUNNING;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Working registers of the item in progress.
	always_ff @(posedge clk) begin
		if (s_accept) begin
			empty_q <= (in_action == ACT_EMPTY);
			last_q  <= (in_next_kind == NK_END);
			key_q   <= {1'b0, in_rune} |
			           (((in_next_kind == NK_NEWLINE) || (in_next_kind == NK_END)) ?
			            KEY_EOL : 17'd0);
			bytes_q <= in_rune_bytes;
		end
		if (state_q == S_SEVAL) begin
			addr_q  <= case_mod(st_rdata.case_base);
			j_q     <= '0;
			count_q <= st_rdata.case_count;
		end
		if (state_q == S_CEVAL) begin
			addr_q <= addr_nx;
			j_q    <= j_q + 13'd1;
			prev_q <= cs_rdata.target;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_EMIT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_EMIT) && out_free) begin
			out_data_q <= best_none_q ? 17'h1FFFF : best_ext[16:0];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_data_q};

endmodule

// ===== bench/range_table_dfa_matcher_tb.sv =====
// ---------------------------------------------------------------------------
// range_table_dfa_matcher_tb
// Self-checking bench for the range-table DFA matcher.
// The state and case tables are loaded in full, then directed texts and
// random texts are run under several start-state settings, followed by one
// long text that drives the byte offset into saturation. A behavioural
// tracker of the DFA predicts each match length, and every result
// transaction is compared with the oldest prediction.
// ---------------------------------------------------------------------------
module range_table_dfa_matcher_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rtm_pkg::*;

	localparam int N_STATES    = 256;
	localparam int N_CASES     = 4096;
	localparam int MAX_BYTES   = 65535;
	localparam int QUIET       = 64;
	localparam int LIMIT       = 3000000;
	localparam int RAND_ITEMS  = 850;
	localparam int PHASE_ITEMS = 80;
	localparam int SAT_RUNES   = 22000;

	// A next_kind code outside the named ones; the block treats it as plain text.
	localparam logic [1:0] NK_ODD = 2'd3;
	// Register index with no register behind it.
	localparam logic [7:0] REG_UNUSED = 8'hFF;

	// States with a fixed role in the loaded tables; random rewrites avoid them.
	localparam logic [7:0] S_LOOP_FINAL = 8'd250;
	localparam logic [7:0] S_LOOP_DEAD  = 8'd251;
	localparam logic [7:0] S_NOCASE     = 8'd252;
	localparam logic [7:0] S_FULL       = 8'd253;
	localparam logic [7:0] S_WRAP       = 8'd254;
	localparam logic [7:0] S_LAST       = 8'd255;

	typedef struct {
		logic [1:0]  act;
		logic [11:0] idx;
		logic        fin;
		logic        lp;
		logic [11:0] base;
		logic [12:0] cnt;
		logic [16:0] key;
		logic [7:0]  tgt;
		logic [15:0] rune;
		logic [1:0]  nbytes;
		logic [1:0]  nk;
		logic        lb;
	} text_item_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [87:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_index;
	logic [7:0]  cfg_data;

	range_table_dfa_matcher uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// Tracked copy of the matcher.
	state_entry_t dfa_state [N_STATES];
	case_entry_t  dfa_case [N_CASES];
	logic [7:0]   start_sel [4];
	logic [7:0]   cur_state;
	int unsigned  text_bytes;
	int           best_len;
	logic [1:0]   freeze;
	bit           in_text;

	logic [16:0] pending_lengths[$];
	int          errors;
	int          cycles;
	int          burst_left;
	int          sink_mode;
	int          sink_left;

	always #2 clk = ~clk;

	function automatic logic [7:0] pick_next(state_entry_t se, logic [16:0] key);
		int          j;
		int          cnt;
		logic [11:0] a;
		cnt = se.case_count;
		if (cnt == 0)
			return cur_state;
		for (j = 0; j < cnt; j++) begin
			a = 12'(se.case_base + j);
			if (dfa_case[a].key > key) begin
				if (j == 0)
					return dfa_case[se.case_base].target;
				a = 12'(se.case_base + j - 1);
				return dfa_case[a].target;
			end
		end
		a = 12'(se.case_base + cnt - 1);
		return dfa_case[a].target;
	endfunction

	task automatic advance_dfa(input text_item_t it);
		state_entry_t se;
		logic [16:0]  key;
		logic [1:0]   sel;
		case (it.act)
			ACT_WR_STATE: begin
				if (it.idx < N_STATES) begin
					dfa_state[it.idx[7:0]].is_final   = it.fin;
					dfa_state[it.idx[7:0]].is_loop    = it.lp;
					dfa_state[it.idx[7:0]].case_base  = it.base;
					dfa_state[it.idx[7:0]].case_count = it.cnt;
				end
			end
			ACT_WR_CASE: begin
				dfa_case[it.idx].key    = it.key;
				dfa_case[it.idx].target = it.tgt;
			end
			ACT_EMPTY: begin
				// Only line_begin counts here; any text in progress is dropped.
				cur_state  = start_sel[{1'b0, it.lb}];
				in_text    = 1'b0;
				freeze     = FRZ_RUNNING;
				text_bytes = 0;
				best_len   = dfa_state[cur_state].is_final ? 0 : -1;
				pending_lengths.push_back(17'(best_len));
			end
			default: begin
				if (!in_text) begin
					sel        = {it.nk == NK_NEWLINE, it.lb};
					cur_state  = start_sel[sel];
					text_bytes = 0;
					best_len   = -1;
					freeze     = FRZ_RUNNING;
					in_text    = 1'b1;
				end
				if (freeze == FRZ_RUNNING) begin
					se = dfa_state[cur_state];
					if (se.is_final)
						best_len = int'(text_bytes);
					if (se.is_loop) begin
						freeze = se.is_final ? FRZ_FINAL : FRZ_NOGROW;
					end else begin
						key       = {it.nk == NK_NEWLINE || it.nk == NK_END, it.rune};
						cur_state = pick_next(se, key);
					end
				end
				text_bytes += 32'(it.nbytes);
				if (text_bytes > MAX_BYTES)
					text_bytes = MAX_BYTES;
				if (it.nk == NK_END) begin
					if (freeze == FRZ_FINAL)
						best_len = int'(text_bytes);
					else if (freeze == FRZ_RUNNING && dfa_state[cur_state].is_final)
						best_len = int'(text_bytes);
					in_text = 1'b0;
					freeze  = FRZ_RUNNING;
					pending_lengths.push_back(17'(best_len));
				end
			end
		endcase
	endtask

	// Fields that the action does not use carry random values.
	function automatic text_item_t junk_item();
		text_item_t it;
		it.act    = 2'($urandom);
		it.idx    = 12'($urandom);
		it.fin    = 1'($urandom);
		it.lp     = 1'($urandom);
		it.base   = 12'($urandom);
		it.cnt    = 13'($urandom);
		it.key    = 17'($urandom);
		it.tgt    = 8'($urandom);
		it.rune   = 16'($urandom);
		it.nbytes = 2'($urandom);
		it.nk     = 2'($urandom);
		it.lb     = 1'($urandom);
		return it;
	endfunction

	task automatic send_item(input text_item_t it);
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 150) :
				$urandom_range(1, 12);
		end
		s_tuser  <= it.act;
		s_tdata  <= {3'b000, it.lb, it.nk, it.nbytes, it.rune, it.tgt, it.key, it.cnt,
			it.base, it.lp, it.fin, it.idx};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		advance_dfa(it);
		burst_left--;
		@(negedge clk);
	endtask

	task automatic send_rune(input logic [15:0] rune, input logic [1:0] nbytes,
			input logic [1:0] nk, input logic lb);
		text_item_t it;
		it        = junk_item();
		it.act    = ACT_RUNE;
		it.rune   = rune;
		it.nbytes = nbytes;
		it.nk     = nk;
		it.lb     = lb;
		send_item(it);
	endtask

	task automatic send_empty(input logic lb);
		text_item_t it;
		it     = junk_item();
		it.act = ACT_EMPTY;
		it.lb  = lb;
		send_item(it);
	endtask

	// Holds the sender off until every predicted result has been taken.
	task automatic wait_results_drained();
		s_tvalid <= 1'b0;
		burst_left = 0;
		@(negedge clk);
		while (pending_lengths.size() != 0) @(negedge clk);
		repeat (QUIET) @(negedge clk);
	endtask

	// Leaves cfg_valid high so that consecutive writes need no low cycle.
	task automatic cfg_write(input logic [7:0] idx, input logic [7:0] data);
		cfg_index <= idx;
		cfg_data  <= data;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx < 4)
			start_sel[idx[1:0]] = data;
		@(negedge clk);
	endtask

	task automatic set_start_states(input logic [7:0] plain, input logic [7:0] lbeg,
			input logic [7:0] lend, input logic [7:0] both);
		cfg_write(REG_START_PLAIN, plain);
		cfg_write(REG_START_LINE_BEGIN, lbeg);
		cfg_write(REG_START_LINE_END, lend);
		cfg_write(REG_START_BOTH, both);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [7:0] pick_start();
		if ($urandom_range(0, 3) == 0)
			return 8'($urandom_range(S_LOOP_FINAL, S_LAST));
		return 8'($urandom);
	endfunction

	// Every entry of both tables is written, so no later walk reads an
	// unwritten entry. Cases come in blocks of sixteen, most of them sorted.
	task automatic test_table_load();
		int         keys[$];
		text_item_t it;
		int         b;
		int         i;
		int         s;
		for (b = 0; b < N_CASES / 16; b++) begin
			keys.delete();
			for (i = 0; i < 16; i++) begin
				if (b % 3 == 0)
					keys.push_back($urandom_range(0, 127) |
						(($urandom_range(0, 3) == 0) ? 32'h10000 : 32'h0));
				else
					keys.push_back(int'(17'($urandom)));
			end
			if (b % 10 != 7)
				keys.sort();
			if (b == 0)
				keys[0] = 0;
			if (b == N_CASES / 16 - 1)
				keys[15] = 32'h1FFFF;
			for (i = 0; i < 16; i++) begin
				it     = junk_item();
				it.act = ACT_WR_CASE;
				it.idx = 12'(b * 16 + i);
				it.key = 17'(keys[i]);
				it.tgt = 8'($urandom);
				send_item(it);
			end
		end
		for (s = 0; s < N_STATES; s++) begin
			it      = junk_item();
			it.act  = ACT_WR_STATE;
			it.idx  = 12'(s);
			it.fin  = ($urandom_range(0, 9) < 4);
			it.lp   = (s != 0) && ($urandom_range(0, 19) == 0);
			it.base = ($urandom_range(0, 3) == 0) ? 12'($urandom) :
				12'($urandom_range(0, 255) * 16);
			it.cnt  = 13'($urandom_range(1, 16));
			if (s == S_LOOP_FINAL) begin
				it.fin = 1'b1;
				it.lp  = 1'b1;
			end else if (s == S_LOOP_DEAD) begin
				it.fin = 1'b0;
				it.lp  = 1'b1;
			end else if (s == S_NOCASE) begin
				it.fin = 1'b0;
				it.lp  = 1'b0;
				it.cnt = 13'd0;
			end else if (s == S_FULL) begin
				it.lp   = 1'b0;
				it.base = 12'd0;
				it.cnt  = 13'd4096;
			end else if (s == S_WRAP) begin
				// The case walk runs off the top of the table and wraps to zero.
				it.lp   = 1'b0;
				it.base = 12'd4088;
				it.cnt  = 13'd16;
			end else if (s == S_LAST) begin
				it.fin  = 1'b1;
				it.lp   = 1'b0;
				it.base = 12'd4095;
				it.cnt  = 13'd1;
			end
			send_item(it);
		end
		// Addresses beyond the state table must leave it untouched.
		it     = junk_item();
		it.act = ACT_WR_STATE;
		it.idx = 12'd256;
		send_item(it);
		it     = junk_item();
		it.act = ACT_WR_STATE;
		it.idx = 12'd4095;
		send_item(it);
	endtask

	task automatic test_directed_texts();
		wait_results_drained();
		cfg_write(REG_UNUSED, 8'h5A);
		set_start_states(S_LOOP_FINAL, S_NOCASE, S_WRAP, S_LAST);
		send_empty(1'b0);
		send_empty(1'b1);
		// Final loop state: the answer is the whole text length.
		send_rune(16'h0061, 2'd1, NK_OTHER, 1'b0);
		send_rune(16'h0000, 2'd3, NK_ODD, 1'b1);
		send_rune(16'hFFFF, 2'd0, NK_END, 1'b0);
		send_rune(16'h0000, 2'd2, NK_NEWLINE, 1'b1);
		send_rune(16'hFFFF, 2'd3, NK_END, 1'b0);
		send_rune(16'h000A, 2'd1, NK_NEWLINE, 1'b0);
		send_rune(16'h0078, 2'd1, NK_OTHER, 1'b0);
		send_rune(16'h0041, 2'd2, NK_END, 1'b1);
		send_rune(16'h0030, 2'd1, NK_OTHER, 1'b1);
		send_rune(16'h0031, 2'd1, NK_END, 1'b0);
		// An empty text arriving mid-text abandons the text in progress.
		send_rune(16'h0062, 2'd1, NK_OTHER, 1'b0);
		send_empty(1'b1);
		send_rune(16'h0063, 2'd3, NK_END, 1'b0);
		send_rune(16'h7FFF, 2'd1, NK_END, 1'b1);
		wait_results_drained();
		set_start_states(S_FULL, S_LOOP_DEAD, 8'd0, S_LAST);
		// The largest key walks every case of the full-table state.
		send_rune(16'hFFFF, 2'd1, NK_END, 1'b0);
		send_rune(16'h0000, 2'd1, NK_OTHER, 1'b1);
		send_rune(16'h0005, 2'd1, NK_END, 1'b0);
	endtask

	task automatic random_text(output int sent);
		text_item_t it;
		int         len;
		int         i;
		int         r;
		logic [1:0] nk;
		logic [15:0] rune;
		logic [1:0] nbytes;
		sent = 0;
		len  = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
		if (len == 0) begin
			send_empty(1'($urandom));
			sent = 1;
			return;
		end
		for (i = 0; i < len; i++) begin
			if ($urandom_range(0, 19) == 0) begin
				it = junk_item();
				if ($urandom_range(0, 1) == 0) begin
					it.act = ACT_WR_CASE;
				end else begin
					it.act = ACT_WR_STATE;
					it.idx = ($urandom_range(0, 1) == 0) ? 12'($urandom_range(0, 239)) :
						12'($urandom_range(256, 4095));
					it.cnt = ($urandom_range(0, 19) == 0) ? 13'd0 :
						13'($urandom_range(1, 16));
				end
				send_item(it);
				sent++;
			end
			if (i > 0 && $urandom_range(0, 29) == 0) begin
				send_empty(1'($urandom));
				sent++;
			end
			if (i == len - 1) begin
				nk = NK_END;
			end else begin
				r  = $urandom_range(0, 9);
				nk = (r < 7) ? NK_OTHER : (r < 9) ? NK_NEWLINE : NK_ODD;
			end
			rune   = ($urandom_range(0, 4) < 3) ? 16'($urandom_range(0, 127)) : 16'($urandom);
			nbytes = ($urandom_range(0, 7) == 0) ? 2'd0 : 2'($urandom_range(1, 3));
			send_rune(rune, nbytes, nk, 1'($urandom));
			sent++;
		end
	endtask

	task automatic test_random_texts();
		int done;
		int phase;
		int n;
		int sent;
		done  = 0;
		phase = 0;
		while (done < RAND_ITEMS) begin
			// Each phase starts once all results are in, so the block is idle.
			wait_results_drained();
			if (phase == 0)
				set_start_states(8'd0, 8'd0, 8'd0, 8'd0);
			else if (phase == 1)
				set_start_states(8'hFF, 8'hFF, 8'hFF, 8'hFF);
			else if (phase == 2)
				set_start_states(S_WRAP, S_LOOP_DEAD, S_NOCASE, S_FULL);
			else
				set_start_states(pick_start(), pick_start(), pick_start(), pick_start());
			n = 0;
			while (n < PHASE_ITEMS && done + n < RAND_ITEMS) begin
				random_text(sent);
				n += sent;
			end
			done += n;
			phase++;
		end
	endtask

	// A frozen final text long enough to push the offset past its maximum.
	task automatic test_offset_saturation();
		int i;
		wait_results_drained();
		set_start_states(S_LOOP_FINAL, S_LOOP_FINAL, S_LOOP_FINAL, S_LOOP_FINAL);
		for (i = 0; i < SAT_RUNES; i++)
			send_rune(16'($urandom), 2'd3, (i == SAT_RUNES - 1) ? NK_END : NK_OTHER,
				1'b0);
	endtask

	// Receiver readiness follows modes of random length: always ready, coin
	// toss, and mostly stalled.
	always @(negedge clk) begin
		if (sink_left == 0) begin
			sink_mode = $urandom_range(0, 2);
			sink_left = $urandom_range(32, 256);
		end
		sink_left--;
		case (sink_mode)
			0:       m_tready <= 1'b1;
			1:       m_tready <= 1'($urandom);
			default: m_tready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	always @(posedge clk) begin : check_results
		logic [16:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_lengths.size() == 0) begin
				$error("match_length: expected none, got %0d", $signed(m_tdata[16:0]));
				errors++;
			end else begin
				want = pending_lengths.pop_front();
				if (m_tdata[16:0] !== want) begin
					$error("match_length: expected %0d, got %0d", $signed(want),
						$signed(m_tdata[16:0]));
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		clk        = 1'b0;
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tuser    = ACT_WR_STATE;
		m_tready   = 1'b0;
		cfg_valid  = 1'b0;
		cfg_index  = REG_START_PLAIN;
		cfg_data   = 8'd0;
		errors     = 0;
		cycles     = 0;
		burst_left = 0;
		sink_mode  = 0;
		sink_left  = 0;
		cur_state  = 8'd0;
		text_bytes = 0;
		best_len   = -1;
		freeze     = FRZ_RUNNING;
		in_text    = 1'b0;
		for (int i = 0; i < 4; i++)
			start_sel[i] = 8'd0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_table_load();
		test_directed_texts();
		test_random_texts();
		test_offset_saturation();
		wait_results_drained();

		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
sv/rtm_pkg.sv
sv/rtm_ram.sv
sv/range_table_dfa_matcher.sv
bench/range_table_dfa_matcher_tb.sv
